### design/postfix_text_stack_evaluator_macros.svh
// Assertion macros shared by the postfix text stack evaluator RTL.
`ifndef POSTFIX_TEXT_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_TEXT_STACK_EVALUATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define PSTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define PSTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/pste_pkg.sv
// Shared types and constants of the postfix text stack evaluator.
`default_nettype none

package pste_pkg;

  // Report status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SYNTAX  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  // Command queue between tokenizer and executor.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    K_NONE,
    K_PUSH,
    K_OP
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_UNKNOWN
  } op_t;

  typedef struct packed {
    kind_t       kind;
    op_t         op;
    logic [31:0] value;
    logic        eot;
    logic        syntax;
  } pste_cmd_t;

endpackage

`default_nettype wire

### design/pste_if.sv
// Valid/ready channel interfaces for text input beats and report beats.
`default_nettype none

interface pste_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] text_byte;

  modport source (output valid, output action, output text_byte, input ready);
  modport sink (input valid, input action, input text_byte, output ready);
endinterface

interface pste_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               entry_valid;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output status, output entry_valid, output value,
                  output last, input ready);
  modport sink (input valid, input status, input entry_valid, input value,
                input last, output ready);
endinterface

`default_nettype wire

### design/pste_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/pste_front.sv
// Tokenizer: classifies text bytes and emits push, operator and end commands.
`default_nettype none

module pste_front #(
  parameter int MAX_TOKEN_LEN = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pste_in_if.sink                in_ch,
  input  wire logic              q_full,
  output logic                   q_push,
  output pste_pkg::pste_cmd_t    q_cmd
);

  import pste_pkg::*;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    M_IDLE,
    M_NUM,
    M_WORD,
    M_MINUS
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        syn_r, syn_nxt;

  logic        beat;
  logic [7:0]  ch;
  logic        is_dig, is_sym, is_spc;
  logic        cont;
  logic [7:0]  len_grow;
  logic [31:0] acc_base, acc_dig;
  logic        len_hit;
  pste_cmd_t   close_cmd;
  pste_cmd_t   cmd;
  logic        emit;

  assign in_ch.ready = !q_full;
  assign beat        = in_ch.valid && in_ch.ready;
  assign ch          = in_ch.text_byte;

  always_comb begin
    is_dig = ch inside {[8'h30:8'h39]};
    is_sym = ch inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_PLUS, CH_MINUS, CH_STAR,
                        CH_SLASH, CH_PCT};
    is_spc = ch inside {CH_SPACE, [8'h09:8'h0D]};
  end

  // The low nibble of an ASCII digit is its value.
  assign len_grow = (len_r == 8'hFF) ? len_r : len_r + 8'd1;
  assign acc_base = (mode_r == M_NUM) ? acc_r : 32'd0;
  assign acc_dig  = (acc_base << 3) + (acc_base << 1) + {28'd0, ch[3:0]};
  assign len_hit  = ({1'b0, len_r} + 9'd1) >= 9'(MAX_TOKEN_LEN);

  // Command that completes the token in progress.
  always_comb begin
    close_cmd        = '0;
    close_cmd.kind   = K_NONE;
    close_cmd.op     = OP_UNKNOWN;
    close_cmd.value  = neg_r ? (32'd0 - acc_r) : acc_r;
    if (mode_r == M_NUM) begin
      close_cmd.kind = K_PUSH;
    end else if (mode_r != M_IDLE) begin
      close_cmd.kind = K_OP;
      if (len_r == 8'd1) begin
        if (first_r == CH_PLUS) begin
          close_cmd.op = OP_ADD;
        end else if (first_r == CH_MINUS) begin
          close_cmd.op = OP_SUB;
        end else if (first_r == CH_STAR) begin
          close_cmd.op = OP_MUL;
        end
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    syn_nxt   = syn_r;
    cmd       = close_cmd;
    emit      = 1'b0;
    cont      = 1'b0;
    if (beat) begin
      if (!in_ch.action) begin
        case (mode_r)
          M_NUM:   cont = is_dig;
          M_MINUS: cont = is_dig || is_sym;
          M_WORD:  cont = is_sym;
          default: cont = 1'b0;
        endcase
        if (cont) begin
          if (is_dig) begin
            mode_nxt = M_NUM;
            neg_nxt  = (mode_r == M_MINUS) ? 1'b1 : neg_r;
            acc_nxt  = acc_dig;
            len_nxt  = len_grow;
            if (len_hit) begin
              syn_nxt = 1'b1;
            end
          end else begin
            mode_nxt = M_WORD;
            len_nxt  = len_grow;
          end
        end else begin
          // Close the pending token, then open a new one with this byte.
          emit     = (close_cmd.kind != K_NONE) && !syn_r;
          mode_nxt = M_IDLE;
          if (!is_spc) begin
            len_nxt = 8'd1;
            if (is_dig) begin
              mode_nxt = M_NUM;
              acc_nxt  = {28'd0, ch[3:0]};
              neg_nxt  = 1'b0;
            end else if (ch == CH_MINUS) begin
              mode_nxt  = M_MINUS;
              first_nxt = ch;
            end else if (is_sym) begin
              mode_nxt  = M_WORD;
              first_nxt = ch;
            end else begin
              len_nxt = 8'd0;
              syn_nxt = 1'b1;
            end
          end
        end
      end else begin
        // End of text: finish the pending token and request the report.
        if (syn_r) begin
          cmd.kind = K_NONE;
        end
        cmd.eot    = 1'b1;
        cmd.syntax = syn_r;
        emit       = 1'b1;
        mode_nxt   = M_IDLE;
        syn_nxt    = 1'b0;
        acc_nxt    = 32'd0;
        neg_nxt    = 1'b0;
        len_nxt    = 8'd0;
        first_nxt  = 8'd0;
      end
    end
  end

  assign q_push = beat && emit;
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      syn_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      syn_r  <= syn_nxt;
    end
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    len_r   <= len_nxt;
    first_r <= first_nxt;
  end

endmodule

`default_nettype wire

### design/pste_queue.sv
// Small command queue that decouples the tokenizer from the executor.
`default_nettype none
`include "postfix_text_stack_evaluator_macros.svh"

module pste_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire pste_pkg::pste_cmd_t  din,
  output logic                      full,
  input  wire logic                 pop,
  output pste_pkg::pste_cmd_t       dout,
  output logic                      empty
);

  import pste_pkg::*;

  pste_cmd_t             slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     cnt_r, cnt_nxt;

  assign full  = cnt_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  `PSTE_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
  `PSTE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !empty)
  `PSTE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH))

endmodule

`default_nettype wire

### design/pste_back.sv
// Executor: runs commands on the stack and streams the end-of-text report.
`default_nettype none
`include "postfix_text_stack_evaluator_macros.svh"

module pste_back #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cmd_valid,
  input  wire pste_pkg::pste_cmd_t  cmd,
  output logic                      cmd_pop,
  pste_out_if.source                out_ch
);

  import pste_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_RUN,
    S_PREP,
    S_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        syn_r, syn_nxt;
  logic [31:0] top_r, top_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic        byp_r;
  logic [31:0] byp_data_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic        out_ev_r, out_ev_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_last_r, out_last_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] wslot, rslot;
  logic [31:0]   rdata, rdv, alu, sel;
  logic          out_free, is_last;

  // The two top entries live in registers; deeper entries live in the RAM.
  // While running, the entry below the second one is read every cycle so a pop finds it ready.
  pste_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (sec_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rdv      = byp_r ? byp_data_r : rdata;
  assign wslot    = count_r - CW'(2);
  assign waddr    = wslot[AW-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = (idx_r + CW'(1)) == count_r;

  always_comb begin
    case (cmd.op)
      OP_ADD:  alu = sec_r + top_r;
      OP_SUB:  alu = sec_r - top_r;
      default: alu = sec_r * top_r;
    endcase
  end

  always_comb begin
    if (({1'b0, idx_r} + (CW + 1)'(2)) < {1'b0, count_r}) begin
      sel = rdv;
    end else if (is_last) begin
      sel = top_r;
    end else begin
      sel = sec_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    err_nxt        = err_r;
    syn_nxt        = syn_r;
    top_nxt        = top_r;
    sec_nxt        = sec_r;
    we             = 1'b0;
    cmd_pop        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_ev_nxt     = out_ev_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_RUN: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_PUSH: begin
              if (err_r == ST_OK) begin
                if (count_r == CW'(STACK_DEPTH)) begin
                  err_nxt = ST_OVER;
                end else begin
                  we        = count_r >= CW'(2);
                  sec_nxt   = top_r;
                  top_nxt   = cmd.value;
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            K_OP: begin
              if (err_r == ST_OK) begin
                if (cmd.op == OP_UNKNOWN) begin
                  err_nxt = ST_UNKNOWN;
                end else if (count_r < CW'(2)) begin
                  err_nxt = ST_UNDER;
                end else begin
                  top_nxt   = alu;
                  sec_nxt   = rdv;
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            default: ;
          endcase
          if (cmd.eot) begin
            state_nxt = S_PREP;
            syn_nxt   = cmd.syntax;
            idx_nxt   = '0;
          end
        end
      end
      S_PREP: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = syn_r ? ST_SYNTAX : err_r;
          if (syn_r || (count_r == '0)) begin
            out_ev_nxt    = 1'b0;
            out_value_nxt = 32'd0;
            out_last_nxt  = 1'b1;
          end else begin
            out_ev_nxt    = 1'b1;
            out_value_nxt = sel;
            out_last_nxt  = is_last;
          end
          if (syn_r || (count_r == '0) || is_last) begin
            state_nxt = S_RUN;
            count_nxt = '0;
            err_nxt   = ST_OK;
            syn_nxt   = 1'b0;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  // Run mode reads the entry that would become second after a pop;
  // report mode walks the stack from the bottom.
  assign rslot = (state_nxt == S_RUN) ? (count_nxt - CW'(3)) : idx_nxt;
  assign raddr = rslot[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      count_r     <= '0;
      idx_r       <= '0;
      err_r       <= ST_OK;
      syn_r       <= 1'b0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      err_r       <= err_nxt;
      syn_r       <= syn_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= we && (waddr == raddr);
    end
    top_r        <= top_nxt;
    sec_r        <= sec_nxt;
    byp_data_r   <= sec_r;
    out_status_r <= out_status_nxt;
    out_ev_r     <= out_ev_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_valid = out_ev_r;
  assign out_ch.value       = $signed(out_value_r);
  assign out_ch.last        = out_last_r;

  `PSTE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(STACK_DEPTH))
  `PSTE_ASSERT_NEXT(a_err_sticky, clk, rst_n, (state_r == S_RUN) && (err_r != ST_OK), err_r == $past(err_r))
  `PSTE_ASSERT_NEXT(a_prep_hold, clk, rst_n, state_r == S_PREP, $stable(count_r) && (state_r == S_EMIT))

endmodule

`default_nettype wire

### design/postfix_text_stack_evaluator.sv
// Top level of the postfix text stack evaluator: tokenizer, command queue, executor.
// Throughput is one text beat per cycle; input stalls only while the four-entry
// command queue is full, which happens while an end-of-text report streams out.
// An end-of-text beat passes the queue, execute, RAM read setup and output register
// steps before its first report beat, then one beat per cycle while ready is high.
// Reset is synchronous and active low; it clears control state but not the stack RAM.
`default_nettype none

module postfix_text_stack_evaluator #(
  parameter int STACK_DEPTH   = 16,
  parameter int MAX_TOKEN_LEN = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pste_in_if.sink    in_ch,
  pste_out_if.source out_ch
);

  import pste_pkg::*;

  // Tokenizer to queue.
  logic      q_push;
  logic      q_full;
  pste_cmd_t q_din;

  // Queue to executor.
  logic      q_pop;
  logic      q_empty;
  pste_cmd_t q_dout;

  // The tokenizer sees each text beat once. A token is closed by the byte
  // after it, so a command for it is queued in the cycle that byte arrives.
  // End of text closes any pending token and asks for the report in the
  // same command.
  pste_front #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_din)
  );

  // The queue lets the tokenizer keep taking text while the executor is
  // busy streaming a report.
  pste_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // The executor does one push or one arithmetic word per cycle outside a report. The stack
  // keeps its two top entries in registers and the rest in a RAM. At end of
  // text it sends the status and the stack bottom first, then clears itself.
  pste_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_dout),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for the postfix text stack evaluator: random and directed programs checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import pste_pkg::*;

  localparam int STACK_DEPTH   = 16;
  localparam int MAX_TOKEN_LEN = 128;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 16;

  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_EOT  = 1'b1;

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_ZERO  = "0";

  // Tokenizer state of the predictor.
  typedef enum logic [1:0] {
    TOK_IDLE,
    TOK_NUM,
    TOK_WORD,
    TOK_MINUS
  } tok_mode_e;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_valid;
    logic [31:0] value;
    logic        last;
  } report_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  pste_in_if  in_ch ();
  pste_out_if out_ch ();

  postfix_text_stack_evaluator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Idling knobs, in percent of cycles, changed between test phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int unsigned cycle_count       = 0;
  int unsigned mismatch_count    = 0;
  int unsigned report_beats_due  = 0;
  int unsigned text_beats_sent   = 0;

  // Report beats that the predictor has computed but the block has not yet sent.
  report_beat_t report_q[$];

  string odd_words[6] = '{"/", "%", "dup", "Zz", "+-", "-q"};

  // ---------------------------------------------------------------------------
  // Predictor: a software copy of the evaluator's stack and tokenizer.
  // ---------------------------------------------------------------------------
  logic [31:0] ev_stack[STACK_DEPTH];
  int unsigned ev_depth;
  tok_mode_e   tok_mode;
  logic [31:0] tok_acc;
  logic        tok_negative;
  int unsigned tok_len;
  logic [7:0]  tok_first;
  logic [2:0]  run_status;

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == "/" || c == "%";
  endfunction

  function void clear_model();
    ev_depth     = 0;
    tok_mode     = TOK_IDLE;
    tok_acc      = '0;
    tok_negative = 1'b0;
    tok_len      = 0;
    tok_first    = '0;
    run_status   = ST_OK;
  endfunction

  function void grow_token();
    if (tok_len < 255) tok_len++;
  endfunction

  // The length check counts the sign, so a number of MAX_TOKEN_LEN characters fails.
  function void append_digit(logic [7:0] c);
    tok_acc = tok_acc * 32'd10 + {24'd0, c - CH_ZERO};
    if (tok_len + 1 >= MAX_TOKEN_LEN) run_status = ST_SYNTAX;
    grow_token();
  endfunction

  // Completes the pending token. Once a runtime error is latched, the stack is frozen.
  function void close_token();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    if (tok_mode == TOK_NUM) begin
      r = tok_negative ? 32'd0 - tok_acc : tok_acc;
      if (run_status == ST_OK) begin
        if (ev_depth >= STACK_DEPTH) begin
          run_status = ST_OVER;
        end else begin
          ev_stack[ev_depth] = r;
          ev_depth++;
        end
      end
    end else if (tok_mode != TOK_IDLE && run_status == ST_OK) begin
      if (tok_len != 1 ||
          !(tok_first == CH_PLUS || tok_first == CH_MINUS || tok_first == CH_STAR)) begin
        run_status = ST_UNKNOWN;
      end else if (ev_depth < 2) begin
        run_status = ST_UNDER;
      end else begin
        b = ev_stack[ev_depth - 1];
        a = ev_stack[ev_depth - 2];
        case (tok_first)
          CH_PLUS:  r = a + b;
          CH_MINUS: r = a - b;
          default:  r = a * b;
        endcase
        ev_depth--;
        ev_stack[ev_depth - 1] = r;
      end
    end
    tok_mode = TOK_IDLE;
  endfunction

  function void eval_text_beat(logic [7:0] c);
    // A character that continues the current token is absorbed here.
    case (tok_mode)
      TOK_NUM: begin
        if (is_digit(c)) begin
          append_digit(c);
          return;
        end
      end
      TOK_MINUS: begin
        if (is_digit(c)) begin
          tok_mode     = TOK_NUM;
          tok_negative = 1'b1;
          tok_acc      = '0;
          append_digit(c);
          return;
        end
        if (is_word_char(c)) begin
          tok_mode = TOK_WORD;
          grow_token();
          return;
        end
      end
      TOK_WORD: begin
        if (is_word_char(c)) begin
          grow_token();
          return;
        end
      end
      default: ;
    endcase
    // Otherwise the token ends and this character may start a new one.
    close_token();
    if (is_blank(c)) return;
    tok_len = 1;
    if (is_digit(c)) begin
      tok_mode     = TOK_NUM;
      tok_acc      = {24'd0, c - CH_ZERO};
      tok_negative = 1'b0;
    end else if (c == CH_MINUS) begin
      tok_mode  = TOK_MINUS;
      tok_first = c;
    end else if (is_word_char(c)) begin
      tok_mode  = TOK_WORD;
      tok_first = c;
    end else begin
      tok_len    = 0;
      run_status = ST_SYNTAX;
    end
  endfunction

  // End of text: a syntax error or an empty stack gives one status-only beat,
  // otherwise one beat per entry, bottom first.
  function void eval_end_of_text();
    report_beat_t rb;
    close_token();
    if (run_status == ST_SYNTAX || ev_depth == 0) begin
      rb = '{run_status, 1'b0, 32'd0, 1'b1};
      report_q.push_back(rb);
      report_beats_due++;
    end else begin
      for (int k = 0; k < ev_depth; k++) begin
        rb = '{run_status, 1'b1, ev_stack[k], k + 1 == ev_depth};
        report_q.push_back(rb);
        report_beats_due++;
      end
    end
    clear_model();
  endfunction

  // ---------------------------------------------------------------------------
  // Clocked processes: watchdog, report receiver and report checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls at random; ready changes only on the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endfunction

  // Every accepted report beat is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    report_beat_t want;
    report_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.entry_valid, out_ch.value, out_ch.last};
      if (report_q.size() == 0) begin
        note_mismatch($sformatf("report beat with none expected: status=%0d entry=%0b value=%0d last=%0b",
                                got.status, got.entry_valid, $signed(got.value), got.last));
      end else begin
        want = report_q.pop_front();
        if (got.status !== want.status || got.entry_valid !== want.entry_valid ||
            got.value !== want.value || got.last !== want.last) begin
          note_mismatch($sformatf({"expected status=%0d entry=%0b value=%0d last=%0b, ",
                                   "got status=%0d entry=%0b value=%0d last=%0b"},
                                  want.status, want.entry_valid, $signed(want.value), want.last,
                                  got.status, got.entry_valid, $signed(got.value), got.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Drives one input beat on the falling edge and holds it until the block takes it.
  // The beat is handed to the predictor at the rising edge where it is accepted.
  task automatic send_beat(logic action, logic [7:0] text_byte);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.action    = action;
    in_ch.text_byte = text_byte;
    do @(posedge clk); while (!in_ch.ready);
    if (action == ACT_EOT) begin
      eval_end_of_text();
    end else begin
      eval_text_beat(text_byte);
      text_beats_sent++;
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(ACT_TEXT, s[i]);
  endtask

  // The byte that travels with an end-of-text beat is meaningless, so it is random.
  task automatic end_text();
    send_beat(ACT_EOT, 8'($urandom_range(0, 255)));
  endtask

  function automatic string digit_run(int n, bit neg);
    string s;
    s = neg ? "-" : "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  // Lowers valid, then holds off until every predicted report beat has arrived.
  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The three math words, wrap-around of numbers and results, negative literals.
  task automatic test_arithmetic();
    send_text("3 4 + 10 3 - 6 7 *");
    end_text();
    send_text("2147483647 1 + 4294967295 1 + 65536 65536 * 99999999999");
    end_text();
    send_text("-5 -3 * 0 -0 - -2147483648");
    end_text();
  endtask

  // All six white-space characters, adjacent tokens of different classes, lone minus.
  task automatic test_separators();
    send_text("1\t2\n3\v4\f5\0156 + - * + -");
    end_text();
    send_text("12-3 5+7*");
    end_text();
    send_text("9 8 - 7 -x 2");
    end_text();
    send_text("4 5 -");
    end_text();
  endtask

  // Reports of an empty stack, including back-to-back end-of-text beats, and an underflow.
  task automatic test_empty_stack();
    end_text();
    end_text();
    send_text(" \t ");
    end_text();
    send_text("1 2 + +");
    end_text();
  endtask

  // Bytes outside the token classes, NUL and high bytes; syntax beats a runtime error.
  task automatic test_syntax_errors();
    send_text("1 2 @ +");
    end_text();
    send_text("8 ");
    send_beat(ACT_TEXT, 8'd0);
    end_text();
    send_text("7 ");
    send_beat(ACT_TEXT, 8'd200);
    send_text(" 3");
    end_text();
    send_text("foo 1 ");
    send_beat(ACT_TEXT, 8'd255);
    end_text();
    send_text("+ 1 #");
    end_text();
  endtask

  // Unknown words, underflow and overflow; only the first runtime error is kept.
  task automatic test_runtime_errors();
    send_text("1 +");
    end_text();
    send_text("1 2 foo 3 + +");
    end_text();
    send_text("5 / 6 +");
    end_text();
    send_text("7 % 2 ++");
    end_text();
    send_text("1 2 3 ++ 4");
    end_text();
    for (int i = 1; i <= STACK_DEPTH + 1; i++) send_text($sformatf("%0d ", i));
    send_text("+ bar");
    end_text();
    for (int i = 0; i < STACK_DEPTH; i++) send_text($sformatf("-%0d ", i * 7919));
    end_text();
  endtask

  // Number tokens right below and at the length limit, with and without a sign.
  // The tokens are still pending when end of text arrives.
  task automatic test_long_numbers();
    send_text(digit_run(MAX_TOKEN_LEN - 1, 1'b0));
    end_text();
    send_text(digit_run(MAX_TOKEN_LEN, 1'b0));
    end_text();
    send_text({"5 ", digit_run(MAX_TOKEN_LEN - 2, 1'b1)});
    end_text();
    send_text(digit_run(MAX_TOKEN_LEN - 1, 1'b1));
    end_text();
  endtask

  // One random program: mostly well-formed postfix with random numbers and
  // separators, some with a stray byte, some pure noise, some that overflow.
  task automatic run_random_program();
    logic [7:0] text[$];
    string      tok;
    int         style;
    int         ntok;
    int         depth;
    int         r;
    bit         push_heavy;
    style      = $urandom_range(0, 99);
    push_heavy = style >= 90;
    ntok       = push_heavy ? $urandom_range(14, 20) : $urandom_range(1, 12);
    depth      = 0;
    if (style < 8) begin
      repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < ntok; i++) begin
        r = $urandom_range(0, 99);
        if (!push_heavy && depth >= 2 && r < 40) begin
          case ($urandom_range(0, 2))
            0:       tok = "+";
            1:       tok = "-";
            default: tok = "*";
          endcase
          depth--;
        end else if (r < 45 && !push_heavy) begin
          tok = ($urandom_range(0, 1) == 0) ? "+" : odd_words[$urandom_range(0, 5)];
        end else begin
          tok = digit_run($urandom_range(1, 11), $urandom_range(0, 3) == 0);
          depth++;
        end
        for (int j = 0; j < tok.len(); j++) text.push_back(tok[j]);
        // Usually one or two blanks; sometimes none, which still splits differing classes.
        if ($urandom_range(0, 6) != 0) begin
          repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(0, 5);
            text.push_back(r == 0 ? 8'd32 : 8'(8 + r));
          end
        end
      end
      if (style < 16) text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
    end
    foreach (text[i]) send_beat(ACT_TEXT, text[i]);
    end_text();
  endtask

  // Random programs under four idling patterns, draining between patterns.
  task automatic test_random_programs();
    int unsigned beats_at_start;
    int unsigned reports_at_start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(48, 0);
        2:       set_idling(0, 48);
        default: set_idling(24, 24);
      endcase
      beats_at_start   = text_beats_sent;
      reports_at_start = report_beats_due;
      while (text_beats_sent - beats_at_start < 65 || report_beats_due - reports_at_start < 15)
        run_random_program();
      wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_TEXT;
    in_ch.text_byte = 8'd0;
    out_ch.ready    = 1'b0;
    clear_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idling(0, 0);
    test_arithmetic();
    test_separators();
    test_empty_stack();
    // Hold the sender back until the directed reports are all in.
    wait_drain();
    set_idling(24, 24);
    test_syntax_errors();
    test_runtime_errors();
    set_idling(0, 0);
    test_long_numbers();
    wait_drain();
    test_random_programs();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
